// File: rtl/pqe_pkg.sv
// Package with the shared types, constants and command bundle of the polyline quad expander.
`timescale 1ns / 1ps
package pqe_pkg;

   // Coordinate and half width formats
   localparam int COORD_W   = 16;
   localparam int HW_W      = 15;
   localparam int HW_RESET  = 8;
   localparam int BIT_IDX_W = 4;

   // Corner codes
   localparam logic [1:0] CORNER_BEGIN_PLUS  = 2'd0;
   localparam logic [1:0] CORNER_BEGIN_MINUS = 2'd1;
   localparam logic [1:0] CORNER_END_PLUS    = 2'd2;
   localparam logic [1:0] CORNER_END_MINUS   = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic                      start_path;
      logic                      close_loop;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic [1:0]                corner;
      logic                      degenerate;
      logic                      last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOADC,
      ST_DIFF,
      ST_MUL1,
      ST_MUL2,
      ST_STEPA,
      ST_STEPB,
      ST_OFFS,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic                 take_point;
      logic                 new_path;
      logic                 load_close;
      logic                 diff;
      logic                 mul1;
      logic                 mul2;
      logic                 step_a;
      logic                 step_b;
      logic                 offs;
      logic [BIT_IDX_W-1:0] bit_idx;
      logic [1:0]           corner;
      logic                 last;
   } cmd_type;

endpackage

// File: rtl/pqe_datapath.sv
// Datapath: point registers, segment geometry, offset search and corner sums.
`timescale 1ns / 1ps
module pqe_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  pqe_pkg::req_type         req_payload,
   input  pqe_pkg::cmd_type         cmd,
   input  logic                     csr_we,
   input  logic [pqe_pkg::HW_W-1:0] csr_wdata,
   output pqe_pkg::rsp_type         rsp_payload
);
   import pqe_pkg::*;

   localparam int A_W  = COORD_W;
   localparam int Q_W  = HW_W;
   localparam int AH_W = A_W + HW_W;
   localparam int S_W  = 2 * A_W + 1;
   localparam int L_W  = 2 * AH_W;
   localparam int P_W  = 2 * Q_W + S_W + 1;
   localparam int QQ_W = Q_W + S_W + 1;
   localparam int T_W  = P_W + 3;

   logic [HW_W-1:0]           half_width_ff;
   logic signed [COORD_W-1:0] prev_x_ff, prev_y_ff, origin_x_ff, origin_y_ff;
   logic signed [COORD_W-1:0] bx_ff, by_ff, ex_ff, ey_ff;
   logic [A_W-1:0]            ax_ff, ay_ff;
   logic                      dxneg_ff, dyneg_ff;
   logic [S_W-1:0]            s_ff;
   logic [AH_W-1:0]           ah_ff [2];
   logic [L_W-1:0]            l_ff [2];
   logic [P_W-1:0]            p_ff [2];
   logic [QQ_W-1:0]           q_ff [2];
   logic [P_W-1:0]            cp_ff [2];
   logic [QQ_W-1:0]           cq_ff [2];
   logic [Q_W-1:0]            m_ff [2];
   logic signed [COORD_W:0]   ox_ff, oy_ff;
   logic                      deg_ff;

   logic signed [COORD_W:0]   dx, dy;
   logic [A_W-1:0]            ax_in, ay_in;
   logic [A_W-1:0]            a_lane [2];
   logic [T_W-1:0]            t_lane [2];
   logic [T_W-1:0]            lim_lane [2];

   function automatic logic signed [COORD_W-1:0] sat(input logic signed [COORD_W+1:0] v);
      logic signed [COORD_W+1:0] top;
      logic signed [COORD_W+1:0] bot;
      top = (COORD_W+2)'((1 << (COORD_W - 1)) - 1);
      bot = -top - (COORD_W+2)'(1);
      if (v > top) begin
         sat = top[COORD_W-1:0];
      end else if (v < bot) begin
         sat = bot[COORD_W-1:0];
      end else begin
         sat = v[COORD_W-1:0];
      end
   endfunction

   // Segment direction and its magnitudes.
   assign dx    = {ex_ff[COORD_W-1], ex_ff} - {bx_ff[COORD_W-1], bx_ff};
   assign dy    = {ey_ff[COORD_W-1], ey_ff} - {by_ff[COORD_W-1], by_ff};
   assign ax_in = dx[COORD_W] ? A_W'(-dx) : A_W'(dx);
   assign ay_in = dy[COORD_W] ? A_W'(-dy) : A_W'(dy);

   // The x offset scales |dy| and the y offset scales |dx|.
   assign a_lane[0] = ay_ff;
   assign a_lane[1] = ax_ff;

   // Compare of the candidate's (2m-1)^2 * s against 4 * (a*h)^2.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         t_lane[i]   = (T_W'(cp_ff[i]) << 2) - (T_W'(cq_ff[i]) << 2) + T_W'(s_ff);
         lim_lane[i] = T_W'(l_ff[i]) << 2;
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff <= HW_W'(HW_RESET);
      end else if (csr_we) begin
         half_width_ff <= csr_wdata;
      end
   end

   // Path state and segment endpoints.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff   <= '0;
         prev_y_ff   <= '0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
      end else if (cmd.take_point) begin
         prev_x_ff <= req_payload.point_x;
         prev_y_ff <= req_payload.point_y;
         if (cmd.new_path) begin
            origin_x_ff <= req_payload.point_x;
            origin_y_ff <= req_payload.point_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_point && !cmd.new_path) begin
         bx_ff <= prev_x_ff;
         by_ff <= prev_y_ff;
         ex_ff <= req_payload.point_x;
         ey_ff <= req_payload.point_y;
      end else if (cmd.load_close) begin
         bx_ff <= prev_x_ff;
         by_ff <= prev_y_ff;
         ex_ff <= origin_x_ff;
         ey_ff <= origin_y_ff;
      end
   end

   // Magnitudes, squares and the bit-serial offset search for both lanes.
   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         ax_ff    <= ax_in;
         ay_ff    <= ay_in;
         dxneg_ff <= dx[COORD_W];
         dyneg_ff <= dy[COORD_W];
      end
      if (cmd.mul1) begin
         s_ff <= S_W'((2 * A_W)'(ax_ff) * (2 * A_W)'(ax_ff))
                 + S_W'((2 * A_W)'(ay_ff) * (2 * A_W)'(ay_ff));
      end
      for (int i = 0; i < 2; i++) begin
         if (cmd.mul1) begin
            ah_ff[i] <= AH_W'(a_lane[i]) * AH_W'(half_width_ff);
         end
         if (cmd.mul2) begin
            l_ff[i] <= L_W'(ah_ff[i]) * L_W'(ah_ff[i]);
            p_ff[i] <= '0;
            q_ff[i] <= '0;
            m_ff[i] <= '0;
         end
         if (cmd.step_a) begin
            cp_ff[i] <= p_ff[i] + (P_W'(q_ff[i]) << (cmd.bit_idx + 1))
                        + (P_W'(s_ff) << (2 * cmd.bit_idx));
            cq_ff[i] <= q_ff[i] + (QQ_W'(s_ff) << cmd.bit_idx);
         end
         if (cmd.step_b && (t_lane[i] <= lim_lane[i])) begin
            p_ff[i] <= cp_ff[i];
            q_ff[i] <= cq_ff[i];
            m_ff[i] <= m_ff[i] | (Q_W'(1) << cmd.bit_idx);
         end
      end
   end

   // Signed offsets, forced to zero on a zero-length segment.
   always_ff @(posedge clock) begin
      if (cmd.offs) begin
         deg_ff <= (s_ff == '0);
         if (s_ff == '0) begin
            ox_ff <= '0;
            oy_ff <= '0;
         end else begin
            ox_ff <= dyneg_ff ? -$signed({1'b0, (COORD_W)'(m_ff[0])})
                              : $signed({1'b0, (COORD_W)'(m_ff[0])});
            oy_ff <= dxneg_ff ? $signed({1'b0, (COORD_W)'(m_ff[1])})
                              : -$signed({1'b0, (COORD_W)'(m_ff[1])});
         end
      end
   end

   // Corner sums with saturation.
   always_comb begin
      logic signed [COORD_W+1:0] base_x, base_y, off_x, off_y;
      base_x = cmd.corner[1] ? (COORD_W+2)'(ex_ff) : (COORD_W+2)'(bx_ff);
      base_y = cmd.corner[1] ? (COORD_W+2)'(ey_ff) : (COORD_W+2)'(by_ff);
      off_x  = (COORD_W+2)'(ox_ff);
      off_y  = (COORD_W+2)'(oy_ff);
      rsp_payload.corner     = cmd.corner;
      rsp_payload.degenerate = deg_ff;
      rsp_payload.last       = cmd.last;
      case (cmd.corner)
         CORNER_BEGIN_PLUS, CORNER_END_PLUS: begin
            rsp_payload.vertex_x = sat(base_x + off_x);
            rsp_payload.vertex_y = sat(base_y + off_y);
         end
         CORNER_BEGIN_MINUS, CORNER_END_MINUS: begin
            rsp_payload.vertex_x = sat(base_x - off_x);
            rsp_payload.vertex_y = sat(base_y - off_y);
         end
         default: begin
            rsp_payload.vertex_x = sat(base_x);
            rsp_payload.vertex_y = sat(base_y);
         end
      endcase
   end

endmodule

// File: rtl/pqe_controller.sv
// Controller: sequences acceptance, offset search and the four corner transfers per segment.
`timescale 1ns / 1ps
module pqe_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_start_path,
   input  logic             req_close_loop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pqe_pkg::cmd_type cmd
);
   import pqe_pkg::*;

   localparam logic [BIT_IDX_W-1:0] TOP_BIT = BIT_IDX_W'(HW_W - 1);

   state_type            state_ff, state_in;
   logic                 have_prev_ff, have_prev_in;
   logic                 close_pend_ff, close_pend_in;
   logic                 final_ff, final_in;
   logic [1:0]           corner_ff, corner_in;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in;
   logic                 new_path;

   assign new_path = req_start_path || !have_prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         have_prev_ff  <= 1'b0;
         close_pend_ff <= 1'b0;
         final_ff      <= 1'b0;
         corner_ff     <= CORNER_BEGIN_PLUS;
         bit_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         have_prev_ff  <= have_prev_in;
         close_pend_ff <= close_pend_in;
         final_ff      <= final_in;
         corner_ff     <= corner_in;
         bit_ff        <= bit_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in      = state_ff;
      have_prev_in  = have_prev_ff;
      close_pend_in = close_pend_ff;
      final_in      = final_ff;
      corner_in     = corner_ff;
      bit_in        = bit_ff;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd           = '0;
      cmd.bit_idx   = bit_ff;
      cmd.corner    = corner_ff;
      cmd.last      = final_ff && (corner_ff == CORNER_END_MINUS);
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_point = 1'b1;
               cmd.new_path   = new_path;
               have_prev_in   = !req_close_loop;
               close_pend_in  = req_close_loop;
               final_in       = !req_close_loop;
               if (!new_path) begin
                  state_in = ST_DIFF;
               end else if (req_close_loop) begin
                  state_in = ST_LOADC;
               end
            end
         end
         ST_LOADC: begin
            cmd.load_close = 1'b1;
            close_pend_in  = 1'b0;
            final_in       = 1'b1;
            state_in       = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            bit_in   = TOP_BIT;
            state_in = ST_STEPA;
         end
         ST_STEPA: begin
            cmd.step_a = 1'b1;
            state_in   = ST_STEPB;
         end
         ST_STEPB: begin
            cmd.step_b = 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_OFFS;
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = ST_STEPA;
            end
         end
         ST_OFFS: begin
            cmd.offs = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               corner_in = corner_ff + 1'b1;
               if (corner_ff == CORNER_END_MINUS) begin
                  state_in = close_pend_ff ? ST_LOADC : ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/polyline_quad_expander_top.sv
// Top level of the polyline quad expander: controller and datapath.
//
//  Channel | Direction | Ports                            | Moves
//  req     | in        | req_valid, req_ready, req_payload | one polyline point
//  rsp     | out       | rsp_valid, rsp_ready, rsp_payload | one quad corner
//  csr     | in        | csr_we, csr_wdata                 | half width register
//
// A point that opens a path is taken in its accepting cycle. Each segment then goes
// through its work (direction, two multiply stages, a 15-bit search for the offset
// magnitude in alternating trial and decide states, the offset signs) before its four
// corner transfers; the closing segment first loads its endpoints.
// Reset is synchronous and clears the controller, the path state and the half width
// register (to 8). The block holds one point at a time; a stalled rsp side holds the
// current corner.
`timescale 1ns / 1ps
module polyline_quad_expander_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pqe_pkg::req_type         req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pqe_pkg::rsp_type         rsp_payload,
   input  logic                     csr_we,
   input  logic [pqe_pkg::HW_W-1:0] csr_wdata
);
   import pqe_pkg::*;

   cmd_type cmd;

   pqe_controller u_controller (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_start_path (req_payload.start_path),
      .req_close_loop (req_payload.close_loop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .cmd            (cmd)
   );

   pqe_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: bench/polyline_quad_expander_checker.sv
// Checker for the polyline quad expander: predicts each corner and compares the rsp transfers.
`timescale 1ns / 1ps
module polyline_quad_expander_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  pqe_pkg::req_type         req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  pqe_pkg::rsp_type         rsp_payload,
   input  logic                     csr_we,
   input  logic [pqe_pkg::HW_W-1:0] csr_wdata,
   output int                       errors,
   output int                       pending
);
   import pqe_pkg::*;

   // Shadow copy of the block's state and its one register.
   logic [HW_W-1:0] half_width;
   int              last_x, last_y, first_x, first_y;
   logic            in_path;
   rsp_type         corner_queue[$];

   task automatic report(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      errors++;
   endtask

   // Clamp a sum to the signed coordinate range.
   function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
      int top;
      top = (1 << (COORD_W - 1)) - 1;
      if (v > top) return COORD_W'(top);
      if (v < -top - 1) return COORD_W'(-top - 1);
      return COORD_W'(v);
   endfunction

   // Offset magnitude round(a * h / sqrt(s)), halves up, found by bisection on exact squares.
   function automatic int offset_magnitude(input longint unsigned a, input longint unsigned h,
                                           input logic [127:0] s);
      logic [127:0]    lhs, rhs;
      longint unsigned t, lo, hi, mid, k;
      t   = 2 * a * h;
      lhs = 128'(t) * 128'(t);
      lo  = 0;
      hi  = h;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         k   = 2 * mid - 1;
         rhs = 128'(k * k) * s;
         if (lhs >= rhs) lo = mid;
         else hi = mid - 1;
      end
      return int'(lo);
   endfunction

   // Queue the four corners of the quad around one segment.
   task automatic expand_segment(input int bx, input int by, input int ex, input int ey,
                                 input logic final_corner);
      int              dx, dy, ox, oy, qx, qy;
      longint unsigned adx, ady;
      logic [127:0]    len_sq;
      logic            zero_len;
      rsp_type         r;
      dx  = ex - bx;
      dy  = ey - by;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      len_sq   = 128'(adx * adx) + 128'(ady * ady);
      zero_len = (len_sq == 0);
      ox = 0;
      oy = 0;
      if (!zero_len) begin
         qx = offset_magnitude(ady, half_width, len_sq);
         qy = offset_magnitude(adx, half_width, len_sq);
         ox = dy < 0 ? -qx : qx;
         oy = dx < 0 ? qy : -qy;
      end
      r.degenerate = zero_len;
      r.last       = 1'b0;
      r.vertex_x = clamp_coord(bx + ox);
      r.vertex_y = clamp_coord(by + oy);
      r.corner   = CORNER_BEGIN_PLUS;
      corner_queue = {corner_queue, r};
      r.vertex_x = clamp_coord(bx - ox);
      r.vertex_y = clamp_coord(by - oy);
      r.corner   = CORNER_BEGIN_MINUS;
      corner_queue = {corner_queue, r};
      r.vertex_x = clamp_coord(ex + ox);
      r.vertex_y = clamp_coord(ey + oy);
      r.corner   = CORNER_END_PLUS;
      corner_queue = {corner_queue, r};
      r.vertex_x = clamp_coord(ex - ox);
      r.vertex_y = clamp_coord(ey - oy);
      r.corner   = CORNER_END_MINUS;
      r.last     = final_corner;
      corner_queue = {corner_queue, r};
   endtask

   // Work out the corners caused by one point.
   task automatic take_point(input req_type p);
      int px, py;
      px = p.point_x;
      py = p.point_y;
      if (p.start_path || !in_path) begin
         first_x = px;
         first_y = py;
      end else begin
         expand_segment(last_x, last_y, px, py, !p.close_loop);
      end
      last_x  = px;
      last_y  = py;
      in_path = 1'b1;
      if (p.close_loop) begin
         expand_segment(px, py, first_x, first_y, 1'b1);
         in_path = 1'b0;
      end
   endtask

   // Follow the register, predict on each req transfer, compare each rsp transfer.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         half_width = HW_W'(HW_RESET);
         last_x = 0;
         last_y = 0;
         first_x = 0;
         first_y = 0;
         in_path = 1'b0;
      end else begin
         if (csr_we) half_width = csr_wdata;
         if (req_valid && req_ready) take_point(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (corner_queue.size() == 0) begin
               report($sformatf("unexpected corner %p", rsp_payload));
            end else begin
               want = corner_queue.pop_front();
               if (rsp_payload.vertex_x !== want.vertex_x)
                  report($sformatf("vertex_x %0d, expected %0d",
                                   rsp_payload.vertex_x, want.vertex_x));
               if (rsp_payload.vertex_y !== want.vertex_y)
                  report($sformatf("vertex_y %0d, expected %0d",
                                   rsp_payload.vertex_y, want.vertex_y));
               if (rsp_payload.corner !== want.corner)
                  report($sformatf("corner %0d, expected %0d",
                                   rsp_payload.corner, want.corner));
               if (rsp_payload.degenerate !== want.degenerate)
                  report($sformatf("degenerate %b, expected %b",
                                   rsp_payload.degenerate, want.degenerate));
               if (rsp_payload.last !== want.last)
                  report($sformatf("last %b, expected %b", rsp_payload.last, want.last));
            end
         end
      end
      pending = corner_queue.size();
   end

   initial errors = 0;

endmodule

// File: bench/polyline_quad_expander_top_test.sv
// Testbench top for the polyline quad expander: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module polyline_quad_expander_top_test;
   import pqe_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 150;
   localparam int HOLD_CYCLES = 400;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_type         req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_type         rsp_payload;
   logic            csr_we = 1'b0;
   logic [HW_W-1:0] csr_wdata = '0;
   int              errors, pending;
   int              cycle = 0;
   int              points_sent = 0;
   int              hold_left = 0;
   logic            hold_done = 1'b0;
   logic            calm;
   int              cur_x = 0, cur_y = 0;

   polyline_quad_expander_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   polyline_quad_expander_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending)
   );

   always #5 clock = ~clock;

   // A stretch of the run in which neither side idles.
   assign calm = cycle >= 6000 && cycle < 10000;

   // Cycle count and the overall limit.
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle >= CYCLE_LIMIT) begin
         $display("** polyline_quad_expander_top: FAILED **");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off once the random part is under way.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && points_sent >= 150) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || $urandom_range(99) >= 13;
      end
   end

   // Offer one point and wait for its transfer.
   task automatic send_point(input int x, input int y, input logic start, input logic close);
      req_type p;
      while (!calm && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      p.point_x    = x[COORD_W-1:0];
      p.point_y    = y[COORD_W-1:0];
      p.start_path = start;
      p.close_loop = close;
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      points_sent++;
      cur_x = x;
      cur_y = y;
   endtask

   // Let the block drain, then write the half width register.
   task automatic set_half_width(input logic [HW_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // A run of random points: mostly whole paths, some noise.
   task automatic random_points(input int count);
      int n, len, i;
      n = 0;
      while (n < count) begin
         if ($urandom_range(99) < 85) begin
            send_point($urandom, $urandom, 1'b1, 1'b0);
            len = $urandom_range(8, 1);
            for (i = 0; i < len; i++) begin
               if ($urandom_range(1))
                  send_point($urandom, $urandom, 1'b0, i == len - 1 && $urandom_range(1));
               else
                  send_point(cur_x + $signed($urandom_range(128)) - 64,
                             cur_y + $signed($urandom_range(128)) - 64,
                             1'b0, i == len - 1 && $urandom_range(1));
            end
            n += len + 1;
         end else begin
            send_point($urandom, $urandom, $urandom_range(1), $urandom_range(1));
            n++;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset half width; first point with no path, long segments, zero length,
      // start and close together.
      send_point(0, 0, 1'b0, 1'b0);
      send_point(32767, 32767, 1'b0, 1'b0);
      send_point(-32768, -32768, 1'b0, 1'b1);
      send_point(100, -100, 1'b1, 1'b1);
      send_point(-32768, 32767, 1'b1, 1'b0);
      send_point(32767, -32768, 1'b0, 1'b0);
      send_point(32767, -32768, 1'b0, 1'b0);
      send_point(5, 0, 1'b0, 1'b1);
      send_point(7, 7, 1'b0, 1'b0);

      // Widest line: saturation at every edge of the range.
      set_half_width(15'h7FFF);
      send_point(0, 0, 1'b1, 1'b0);
      send_point(3, 4, 1'b0, 1'b0);
      send_point(32767, 0, 1'b0, 1'b0);
      send_point(-32768, 0, 1'b0, 1'b0);
      send_point(0, -32768, 1'b0, 1'b1);

      // Zero width and unit width, where rounding of halves matters.
      set_half_width('0);
      send_point(10, 10, 1'b1, 1'b0);
      send_point(-10, 30, 1'b0, 1'b1);
      set_half_width(15'd1);
      send_point(0, 0, 1'b1, 1'b0);
      send_point(1, 1, 1'b0, 1'b0);
      send_point(3, 1, 1'b0, 1'b0);
      send_point(3, 5, 1'b0, 1'b1);

      // Random part over several widths.
      set_half_width(HW_W'($urandom));
      random_points(66);
      set_half_width(15'd4096);
      random_points(66);
      set_half_width(15'h7FFF);
      random_points(66);
      set_half_width(15'd1);
      random_points(66);
      set_half_width(HW_W'($urandom_range(64)));
      random_points(66);

      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("** polyline_quad_expander_top: PASSED **");
      else
         $display("** polyline_quad_expander_top: FAILED **");
      $finish;
   end

endmodule
